// ===== hw/rtl/prtt_pkg.sv =====
// Shared types, codes and helper functions for the pending request timeout table.
// No dependencies; imported by every module of the block.
package prtt_pkg;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TMO_W  = 31;

  // input operation codes
  localparam logic [2:0] OP_TRACK_SUBMIT  = 3'd0;
  localparam logic [2:0] OP_TRACK_CANCEL  = 3'd1;
  localparam logic [2:0] OP_TRACK_REPLACE = 3'd2;
  localparam logic [2:0] OP_CLEAR         = 3'd3;
  localparam logic [2:0] OP_QUERY         = 3'd4;
  localparam logic [2:0] OP_CHECK         = 3'd5;

  // result kinds
  localparam logic [2:0] RK_DONE    = 3'd0;
  localparam logic [2:0] RK_QUERY   = 3'd1;
  localparam logic [2:0] RK_EXPIRED = 3'd2;
  localparam logic [2:0] RK_NONE    = 3'd3;
  localparam logic [2:0] RK_FULL    = 3'd4;

  // entry kinds
  localparam logic [1:0] EK_SUBMIT  = 2'd0;
  localparam logic [1:0] EK_CANCEL  = 2'd1;
  localparam logic [1:0] EK_REPLACE = 2'd2;

  // expiry policies
  localparam logic [1:0] POL_LOG       = 2'd0;
  localparam logic [1:0] POL_REJECT    = 2'd1;
  localparam logic [1:0] POL_CALLBACK  = 2'd2;
  localparam logic [1:0] POL_RECONCILE = 2'd3;

  // log classes
  localparam logic [1:0] LOG_NONE = 2'd0;
  localparam logic [1:0] LOG_WARN = 2'd1;
  localparam logic [1:0] LOG_INFO = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SUBMIT_TMO  = 3'd0;
  localparam logic [2:0] REG_CANCEL_TMO  = 3'd1;
  localparam logic [2:0] REG_REPLACE_TMO = 3'd2;
  localparam logic [2:0] REG_POLICY      = 3'd3;
  localparam logic [2:0] REG_REJECT_HND  = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_HND = 3'd5;

  localparam logic [TMO_W-1:0] TMO_RESET = 31'd5000;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [1:0]        kind;
    logic [TIME_W-1:0] start;
  } prtt_entry_t;

  typedef struct packed {
    logic [1:0] log_class;
    logic       nrej;
    logic       ntmo;
  } prtt_notify_t;

  typedef struct packed {
    logic              check_mode;
    logic [ID_W-1:0]   key_id;
    logic [TIME_W-1:0] now;
    logic [TMO_W-1:0]  timeout;
  } prtt_cmp_req_t;

  function automatic prtt_notify_t expiry_notify(input logic [1:0] policy,
                                                 input logic rej_hnd,
                                                 input logic tmo_hnd);
    prtt_notify_t n;
    n = '0;
    case (policy)
      POL_LOG: n.log_class = LOG_WARN;
      POL_REJECT: begin
        n.log_class = LOG_WARN;
        n.nrej      = rej_hnd;
      end
      POL_CALLBACK: begin
        if (tmo_hnd) n.ntmo = 1'b1;
        else         n.log_class = LOG_WARN;
      end
      default: begin
        n.log_class = LOG_INFO;
        n.ntmo      = tmo_hnd;
      end
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/prtt_cmp.sv =====
// Shared compare unit: id match for lookups, elapsed-time test for expiry.
// Depends on prtt_pkg.
module prtt_cmp (
  input  prtt_pkg::prtt_cmp_req_t req,
  input  prtt_pkg::prtt_entry_t   entry,
  output logic                    hit
);
  import prtt_pkg::*;

  logic [TIME_W-1:0] elapsed;

  always_comb begin
    elapsed = req.now - entry.start;
    if (req.check_mode) hit = (elapsed >= {1'b0, req.timeout});
    else                hit = (entry.id == req.key_id);
  end

endmodule

// ===== hw/rtl/prtt_table.sv =====
// Entry storage: one write port, one registered read port.
// Depends on prtt_pkg.
module prtt_table #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IW    = 5
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IW-1:0]         waddr,
  input  prtt_pkg::prtt_entry_t wdata,
  input  logic [IW-1:0]         raddr,
  output prtt_pkg::prtt_entry_t rdata
);
  import prtt_pkg::*;

  prtt_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pending_request_timeout_table_unit.sv =====
// Pending request timeout table: sequencer, slot valid bits, config registers.
// Depends on prtt_pkg, prtt_cmp and prtt_table.
//
// Usage: items enter on the in_ stream (in_tuser = operation, in_tdata = id and
// time). Track, clear and query give one result; check gives one result per
// expired entry in slot order, or one "none" result; codes 6 and 7 are dropped.
// in_tlast is absent; out_tlast marks the final result of an item.
// Every item walks all slots through the one shared compare unit; each slot
// is read, then evaluated, because the entry memory has a registered read
// port. A check then reports each expired entry in the steps read, load and
// output, and passes over skipped slots. in_tready is high only while no
// item is in work.
// Results wait in the output register while out_tready is low; the sequencer
// holds until the transaction completes. Reset empties the table (valid bits
// cleared at once, no clearing pass) and restores the register defaults.
// Registers are written over the cfg_ APB port at byte address 4*index.
module pending_request_timeout_table_unit #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // request_id[31:0], now_ms[63:32]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_id[31:0], expired_kind[33:32],
                                  // entry_found[34], pending_total[40:35],
                                  // log_class[42:41], notify_reject[43],
                                  // notify_timeout[44], zero fill[47:45]
  output logic [2:0]  out_tuser,  // result_kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import prtt_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_FINISH, S_EMIT_RD, S_EMIT_EV, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [TMO_W-1:0] submit_tmo_r, cancel_tmo_r, replace_tmo_r;
  logic [1:0]       policy_r;
  logic             rej_hnd_r, tmo_hnd_r;
  logic [2:0]       cfg_idx;
  logic             cfg_wr;

  // item and scan state
  logic [2:0]        op_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] now_r;
  logic [IW-1:0]     idx_r, hit_r, free_r;
  logic              found_r, free_ok_r, any_exp_r;
  logic [TABLE_DEPTH-1:0] valid_r, exp_mask_r, rest_mask;
  logic [CW-1:0]     count_r;

  // output register
  logic              out_valid_r, out_last_r, out_found_r, out_nrej_r, out_ntmo_r;
  logic [2:0]        out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic [1:0]        out_ek_r, out_log_r;
  logic [5:0]        out_total_r;

  prtt_entry_t   rd_entry, wr_entry;
  prtt_cmp_req_t cmp_req;
  prtt_notify_t  notify;
  logic          cmp_hit, tbl_we, is_track;
  logic [IW-1:0] wr_addr;

  assign is_track = (op_r == OP_TRACK_SUBMIT) || (op_r == OP_TRACK_CANCEL) ||
                    (op_r == OP_TRACK_REPLACE);

  always_comb begin
    cmp_req.check_mode = (op_r == OP_CHECK);
    cmp_req.key_id     = id_r;
    cmp_req.now        = now_r;
    case (rd_entry.kind)
      EK_CANCEL:  cmp_req.timeout = cancel_tmo_r;
      EK_REPLACE: cmp_req.timeout = replace_tmo_r;
      default:    cmp_req.timeout = submit_tmo_r;
    endcase
  end

  prtt_cmp u_cmp (
    .req   (cmp_req),
    .entry (rd_entry),
    .hit   (cmp_hit)
  );

  assign tbl_we         = (state_r == S_FINISH) && is_track && (found_r || free_ok_r);
  assign wr_addr        = found_r ? hit_r : free_r;
  assign wr_entry.id    = id_r;
  assign wr_entry.kind  = op_r[1:0];
  assign wr_entry.start = now_r;

  prtt_table #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  assign notify    = expiry_notify(policy_r, rej_hnd_r, tmo_hnd_r);
  assign rest_mask = exp_mask_r & ~(TABLE_DEPTH'(1) << idx_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      exp_mask_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_tuser;
            id_r       <= in_tdata[31:0];
            now_r      <= in_tdata[63:32];
            idx_r      <= '0;
            found_r    <= 1'b0;
            free_ok_r  <= 1'b0;
            any_exp_r  <= 1'b0;
            exp_mask_r <= '0;
            // drop unknown operation codes
            if (in_tuser <= OP_CHECK) state_r <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (op_r == OP_CHECK) begin
            if (valid_r[idx_r] && cmp_hit) begin
              valid_r[idx_r]    <= 1'b0;
              exp_mask_r[idx_r] <= 1'b1;
              count_r           <= count_r - CW'(1);
              any_exp_r         <= 1'b1;
            end
          end else begin
            if (valid_r[idx_r] && cmp_hit && !found_r) begin
              found_r <= 1'b1;
              hit_r   <= idx_r;
            end
            if (!valid_r[idx_r] && !free_ok_r) begin
              free_ok_r <= 1'b1;
              free_r    <= idx_r;
            end
          end
          if (idx_r == LAST_IDX) begin
            state_r <= S_FINISH;
          end else begin
            idx_r   <= idx_r + IW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_FINISH: begin
          out_id_r    <= id_r;
          out_ek_r    <= EK_SUBMIT;
          out_found_r <= 1'b0;
          out_log_r   <= LOG_NONE;
          out_nrej_r  <= 1'b0;
          out_ntmo_r  <= 1'b0;
          out_last_r  <= 1'b1;
          out_total_r <= 6'(count_r);
          state_r     <= S_OUT;
          out_valid_r <= 1'b1;
          case (op_r)
            OP_CLEAR: begin
              out_kind_r  <= RK_DONE;
              out_found_r <= found_r;
              if (found_r) begin
                valid_r[hit_r] <= 1'b0;
                count_r        <= count_r - CW'(1);
                out_total_r    <= 6'(count_r - CW'(1));
              end
            end
            OP_QUERY: begin
              out_kind_r  <= RK_QUERY;
              out_found_r <= found_r;
            end
            OP_CHECK: begin
              out_kind_r <= RK_NONE;
              out_id_r   <= '0;
              if (any_exp_r) begin
                idx_r       <= '0;
                out_valid_r <= 1'b0;
                state_r     <= S_EMIT_RD;
              end
            end
            default: begin
              if (found_r) begin
                out_kind_r <= RK_DONE;
              end else if (free_ok_r) begin
                out_kind_r      <= RK_DONE;
                valid_r[free_r] <= 1'b1;
                count_r         <= count_r + CW'(1);
                out_total_r     <= 6'(count_r + CW'(1));
              end else begin
                out_kind_r <= RK_FULL;
              end
            end
          endcase
        end
        S_EMIT_RD: begin
          // skip slots that did not expire
          if (exp_mask_r[idx_r]) state_r <= S_EMIT_EV;
          else                   idx_r   <= idx_r + IW'(1);
        end
        S_EMIT_EV: begin
          out_kind_r        <= RK_EXPIRED;
          out_id_r          <= rd_entry.id;
          out_ek_r          <= rd_entry.kind;
          out_found_r       <= 1'b0;
          out_log_r         <= notify.log_class;
          out_nrej_r        <= notify.nrej;
          out_ntmo_r        <= notify.ntmo;
          out_total_r       <= 6'(count_r);
          out_last_r        <= (rest_mask == '0);
          exp_mask_r[idx_r] <= 1'b0;
          out_valid_r       <= 1'b1;
          state_r           <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + IW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_ntmo_r, out_nrej_r, out_log_r, out_total_r,
                       out_found_r, out_ek_r, out_id_r};

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      submit_tmo_r  <= TMO_RESET;
      cancel_tmo_r  <= TMO_RESET;
      replace_tmo_r <= TMO_RESET;
      policy_r      <= POL_LOG;
      rej_hnd_r     <= 1'b0;
      tmo_hnd_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SUBMIT_TMO:  submit_tmo_r  <= cfg_pwdata[TMO_W-1:0];
        REG_CANCEL_TMO:  cancel_tmo_r  <= cfg_pwdata[TMO_W-1:0];
        REG_REPLACE_TMO: replace_tmo_r <= cfg_pwdata[TMO_W-1:0];
        REG_POLICY:      policy_r      <= cfg_pwdata[1:0];
        REG_REJECT_HND:  rej_hnd_r     <= cfg_pwdata[0];
        REG_TIMEOUT_HND: tmo_hnd_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SUBMIT_TMO:  cfg_prdata = {1'b0, submit_tmo_r};
      REG_CANCEL_TMO:  cfg_prdata = {1'b0, cancel_tmo_r};
      REG_REPLACE_TMO: cfg_prdata = {1'b0, replace_tmo_r};
      REG_POLICY:      cfg_prdata = {30'd0, policy_r};
      REG_REJECT_HND:  cfg_prdata = {31'd0, rej_hnd_r};
      REG_TIMEOUT_HND: cfg_prdata = {31'd0, tmo_hnd_r};
      default:         cfg_prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while a result waits");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("pending count above depth");
  a_full_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == RK_FULL) |-> count_r == CW'(TABLE_DEPTH))
    else $error("table full reported with free slots");
  a_mask_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> exp_mask_r == '0)
    else $error("expired entries left unreported");
`endif

endmodule
